/* rtl/urbt_pkg.sv */
// ----------------------------------------------------------------------------
// urbt_pkg
// Types and constants shared by the unlock relay backoff timer.
// ----------------------------------------------------------------------------
package urbt_pkg;

	localparam int RAND_W   = 32;
	localparam int PERIOD_W = 20;
	localparam int DELTA_W  = 19;
	localparam int MOD_W    = DELTA_W + 1;
	localparam int LEN_W    = PERIOD_W + 1;
	localparam int CFG_W    = PERIOD_W;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);
	localparam logic [DELTA_W-1:0]  DELTA_RESET  = DELTA_W'(100);

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_EDGE  = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	localparam logic [1:0] CAUSE_NONE  = 2'd0;
	localparam logic [1:0] CAUSE_TIMER = 2'd1;
	localparam logic [1:0] CAUSE_EDGE  = 2'd2;

	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_DELTA  = 1'b1;

	typedef struct packed {
		logic [1:0]        action;
		logic [RAND_W-1:0] rand_jitter;
		logic [RAND_W-1:0] rand_backoff;
	} in_beat_t;

	typedef struct packed {
		logic       unlock_pulse;
		logic [1:0] pulse_cause;
		logic       force_quiet;
		logic       edge_accepted;
	} out_beat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/urbt_moddiv.sv */
// ----------------------------------------------------------------------------
// urbt_moddiv
// Restoring bit-serial modulo unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module urbt_moddiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [urbt_pkg::RAND_W-1:0] dividend,
	input  logic [urbt_pkg::MOD_W-1:0]  divisor,
	output urbt_pkg::div_stat_t         stat,
	output logic [urbt_pkg::MOD_W-1:0]  remainder
);

	localparam int STEPS = urbt_pkg::RAND_W;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [urbt_pkg::MOD_W-1:0]    rem_q;
	logic [urbt_pkg::RAND_W-1:0]   dvd_q;
	logic [urbt_pkg::MOD_W:0]      trial;
	logic [urbt_pkg::MOD_W:0]      rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[urbt_pkg::RAND_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = trial - {1'b0, divisor};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next[urbt_pkg::MOD_W-1:0];
			dvd_q <= {dvd_q[urbt_pkg::RAND_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = (divisor == '0) ? '0 : rem_q;

endmodule

/* rtl/unlock_relay_backoff_timer_core.sv */
// ----------------------------------------------------------------------------
// unlock_relay_backoff_timer_core
// Relays unlock edges, holds force-quiet for a random backoff and runs a
// jittered one-shot timer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall   in_data  (urbt_pkg::in_beat_t)
//  out      out  out_valid / out_stall out_data (urbt_pkg::out_beat_t)
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// Tick, start, rejected edge and unused action: result registered, shown in the cycle after acceptance.
// Accepted edge: 2 x 32 steps of the shared modulo unit (jitter, then backoff), result registered.
// in_stall is high while an edge is in the modulo unit or a result waits.
// Reset loads period 20000, delta 100 and clears timer and quiet state.
module unlock_relay_backoff_timer_core #(
	parameter int COUNTER_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  urbt_pkg::in_beat_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output urbt_pkg::out_beat_t           out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [urbt_pkg::CFG_W-1:0]    cfg_data
);

	localparam int CW  = COUNTER_BITS;
	localparam int PW  = urbt_pkg::PERIOD_W;
	localparam int MW  = urbt_pkg::MOD_W;
	localparam int LW  = urbt_pkg::LEN_W;
	localparam int QW  = urbt_pkg::MOD_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DIV_J = 2'd1;
	localparam logic [1:0] S_DIV_B = 2'd2;

	logic [1:0]                     state_q;
	logic [PW-1:0]                  period_q;
	logic [urbt_pkg::DELTA_W-1:0]   delta_q;
	logic [CW-1:0]                  since_q;
	logic [CW-1:0]                  prev_q;
	logic [LW-1:0]                  timer_q;
	logic                           armed_q;
	logic [QW-1:0]                  quiet_q;
	logic [LW-1:0]                  load_q;
	logic [LW-1:0]                  len1_q;
	logic [urbt_pkg::RAND_W-1:0]    rb_q;
	logic                           out_valid_q;
	urbt_pkg::out_beat_t            out_q;

	logic                           in_acc;
	logic                           out_free;
	logic                           edge_ok;
	logic                           div_start;
	logic [urbt_pkg::RAND_W-1:0]    div_dividend;
	logic [MW-1:0]                  div_m;
	logic [MW-1:0]                  div_rem;
	urbt_pkg::div_stat_t            div_stat;
	logic [LW-1:0]                  len1_next;
	logic [LW-1:0]                  len_next;
	logic                           fire;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign edge_ok  = {since_q, 1'b0} >= (CW+1)'(period_q);
	assign fire     = armed_q && (timer_q <= LW'(1));
	assign div_m    = {delta_q, 1'b0};

	assign div_start = (in_acc && in_data.action == urbt_pkg::ACT_EDGE && edge_ok)
		|| (state_q == S_DIV_J && div_stat.done);
	assign div_dividend = (state_q == S_IDLE) ? in_data.rand_jitter : rb_q;

	always_comb begin
		if (prev_q <= CW'(period_q)) begin
			len1_next = {1'b0, period_q} + {1'b0, div_rem};
		end else if (period_q > div_rem) begin
			len1_next = {1'b0, period_q} - {1'b0, div_rem};
		end else begin
			len1_next = '0;
		end
		if (len1_q > {1'b0, div_rem}) begin
			len_next = len1_q - {1'b0, div_rem};
		end else begin
			len_next = '0;
		end
	end

	urbt_moddiv u_moddiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_m),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= urbt_pkg::PERIOD_RESET;
			delta_q  <= urbt_pkg::DELTA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				urbt_pkg::REG_PERIOD: period_q <= cfg_data;
				urbt_pkg::REG_DELTA:  delta_q  <= cfg_data[urbt_pkg::DELTA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			since_q     <= '0;
			prev_q      <= '1;
			timer_q     <= '0;
			armed_q     <= 1'b0;
			quiet_q     <= '0;
			load_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_data.action)
							urbt_pkg::ACT_TICK: begin
								out_valid_q <= 1'b1;
								if (since_q != '1) begin
									since_q <= since_q + 1'b1;
								end
								if (fire) begin
									armed_q <= 1'b0;
									timer_q <= '0;
								end else if (armed_q) begin
									timer_q <= timer_q - 1'b1;
								end
								if (quiet_q != '0) begin
									quiet_q <= quiet_q - 1'b1;
									if (quiet_q == QW'(1)) begin
										armed_q <= 1'b1;
										timer_q <= load_q;
									end
								end
							end
							urbt_pkg::ACT_EDGE: begin
								if (edge_ok) begin
									state_q <= S_DIV_J;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							urbt_pkg::ACT_START: begin
								out_valid_q <= 1'b1;
								since_q     <= '0;
								armed_q     <= 1'b1;
								timer_q     <= LW'(period_q);
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_DIV_J: begin
					if (div_stat.done) begin
						state_q <= S_DIV_B;
					end
				end
				S_DIV_B: begin
					if (div_stat.done) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						prev_q      <= since_q;
						since_q     <= '0;
						load_q      <= len_next;
						quiet_q     <= div_rem;
						if (div_rem == '0) begin
							armed_q <= 1'b1;
							timer_q <= len_next;
						end else begin
							armed_q <= 1'b0;
							timer_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rb_q                <= in_data.rand_backoff;
			out_q.unlock_pulse  <= 1'b0;
			out_q.pulse_cause   <= urbt_pkg::CAUSE_NONE;
			out_q.edge_accepted <= 1'b0;
			out_q.force_quiet   <= quiet_q != '0;
			if (in_data.action == urbt_pkg::ACT_TICK) begin
				out_q.force_quiet <= quiet_q > QW'(1);
				if (fire) begin
					out_q.unlock_pulse <= 1'b1;
					out_q.pulse_cause  <= urbt_pkg::CAUSE_TIMER;
				end
			end
		end
		if (state_q == S_DIV_J && div_stat.done) begin
			len1_q <= len1_next;
		end
		if (state_q == S_DIV_B && div_stat.done) begin
			out_q.unlock_pulse  <= 1'b1;
			out_q.pulse_cause   <= urbt_pkg::CAUSE_EDGE;
			out_q.edge_accepted <= 1'b1;
			out_q.force_quiet   <= div_rem != '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while an edge is in progress");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV_J || state_q == S_DIV_B))
		else $error("modulo unit finished outside an edge sequence");

	a_disarmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (timer_q == '0))
		else $error("disarmed timer holds a count");

	a_edge_no_result_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_B && div_stat.done) |-> !out_valid_q)
		else $error("edge result would overwrite a pending beat");
`endif

endmodule
